// ===== design/acmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_pkg: shared types and constants of the alarm clock mode controller
// Holds the mode encoding, key codes, register indexes and the state,
// configuration and result records used by the step logic and the top level.
// ----------------------------------------------------------------------------
package acmc_pkg;

   // one-hot mode encoding
   typedef enum logic [4:0] {
      ST_NORMAL      = 5'b00001,
      ST_SET_HOUR    = 5'b00010,
      ST_SET_MIN     = 5'b00100,
      ST_ALARM_HOUR  = 5'b01000,
      ST_ALARM_MIN   = 5'b10000
   } mode_type;

   // mode codes as they appear on the result beat
   localparam logic [2:0] MODE_CODE_NORMAL       = 3'd0;
   localparam logic [2:0] MODE_CODE_SET_HOUR     = 3'd1;
   localparam logic [2:0] MODE_CODE_SET_MINUTE   = 3'd2;
   localparam logic [2:0] MODE_CODE_ALARM_HOUR   = 3'd3;
   localparam logic [2:0] MODE_CODE_ALARM_MINUTE = 3'd4;

   // decoded key codes
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_SETUP = 3'd1;
   localparam logic [2:0] KEY_ALARM = 3'd2;
   localparam logic [2:0] KEY_PLUS  = 3'd3;
   localparam logic [2:0] KEY_MINUS = 3'd4;

   // request kinds
   localparam logic REQ_MS_TICK  = 1'b0;
   localparam logic REQ_SEC_TICK = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_EDIT_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_BLINK_HALF   = 3'd1;
   localparam logic [2:0] CSR_PIP_LENGTH   = 3'd2;
   localparam logic [2:0] CSR_ALARM_LENGTH = 3'd3;
   localparam logic [2:0] CSR_ALARM_ON     = 3'd4;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned RSP_DATA_W  = 24;

   localparam logic [4:0] HOUR_TOP      = 5'd23;
   localparam logic [5:0] MINUTE_TOP    = 6'd59;
   localparam logic [6:0] MINUTES_HOUR  = 7'd60;
   localparam logic [6:0] SECONDS_MIN   = 7'd60;
   localparam logic [5:0] HOURS_DAY     = 6'd24;

   typedef struct packed {
      logic [5:0]  edit_timeout;
      logic [9:0]  blink_half;
      logic [12:0] pip_length;
      logic [12:0] alarm_length;
      logic [9:0]  alarm_on;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      edit_timeout: 6'd30,
      blink_half:   10'd500,
      pip_length:   13'd300,
      alarm_length: 13'd5000,
      alarm_on:     10'd500
   };

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic [4:0]  edit_hour;
      logic [5:0]  edit_minute;
      mode_type    mode;
      logic [5:0]  timeout_left;
      logic [9:0]  blink_count;
      logic        blink_phase;
      logic [12:0] buzz_left;
      logic [10:0] buzz_cycle;
      logic        buzz_alarm;
      logic        buzz_level;
   } state_type;

   localparam state_type STATE_RESET = '{
      hour:         5'd0,
      minute:       6'd0,
      second:       6'd0,
      alarm_hour:   5'd0,
      alarm_minute: 6'd0,
      edit_hour:    5'd0,
      edit_minute:  6'd0,
      mode:         ST_NORMAL,
      timeout_left: 6'd0,
      blink_count:  10'd0,
      blink_phase:  1'b1,
      buzz_left:    13'd0,
      buzz_cycle:   11'd0,
      buzz_alarm:   1'b0,
      buzz_level:   1'b0
   };

   typedef struct packed {
      logic       save_alarm;
      logic [2:0] clock_mode;
      logic       alarm_led;
      logic       buzzer_drive;
      logic       minute_visible;
      logic       hour_visible;
      logic [5:0] shown_minute;
      logic [4:0] shown_hour;
   } result_type;

endpackage

// ===== design/acmc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_step: next-state and display logic for one tick beat
// Millisecond ticks run the buzzer, the blink phase and the key; second
// ticks run the time of day and the edit timeout.
// ----------------------------------------------------------------------------
module acmc_step (
   input  acmc_pkg::state_type  state_cur,
   input  acmc_pkg::cfg_type    cfg,
   input  logic                 req_type,
   input  logic [2:0]           key,
   output acmc_pkg::state_type  state_next,
   output acmc_pkg::result_type result
);

   function automatic logic [5:0] inc_wrap(input logic [5:0] v, input logic [5:0] top);
      return (v >= top) ? 6'd0 : v + 6'd1;
   endfunction

   function automatic logic [5:0] dec_wrap(input logic [5:0] v, input logic [5:0] top);
      return (v == 6'd0 || v > top) ? top : v - 6'd1;
   endfunction

   logic save;

   always_comb begin : next_state
      acmc_pkg::state_type s;
      logic [10:0] blink_c;
      logic [10:0] cyc;
      logic [6:0]  sec_c;
      logic [6:0]  min_c;
      logic [5:0]  hour_c;
      logic        up;
      s       = state_cur;
      save    = 1'b0;
      blink_c = '0;
      cyc     = '0;
      sec_c   = '0;
      min_c   = '0;
      hour_c  = '0;
      up      = (key == acmc_pkg::KEY_PLUS);
      if (req_type == acmc_pkg::REQ_MS_TICK) begin
         // buzzer
         if (s.buzz_left == 13'd0) begin
            s.buzz_level = 1'b0;
         end else begin
            s.buzz_left = s.buzz_left - 13'd1;
            if (!s.buzz_alarm) begin
               s.buzz_level = 1'b1;
            end else begin
               cyc = s.buzz_cycle + 11'd1;
               s.buzz_cycle = cyc;
               if (cyc < {1'b0, cfg.alarm_on}) begin
                  s.buzz_level = 1'b1;
               end else if ({1'b0, cyc} < {1'b0, cfg.alarm_on, 1'b0}) begin
                  s.buzz_level = 1'b0;
               end else begin
                  s.buzz_cycle = 11'd0;
               end
            end
            if (s.buzz_left == 13'd0) begin
               s.buzz_level = 1'b0;
               s.buzz_alarm = 1'b0;
               s.buzz_cycle = 11'd0;
            end
         end
         // blink phase
         blink_c = {1'b0, s.blink_count} + 11'd1;
         if (blink_c >= {1'b0, cfg.blink_half}) begin
            s.blink_count = 10'd0;
            s.blink_phase = ~s.blink_phase;
         end else begin
            s.blink_count = blink_c[9:0];
         end
         // key: every valid key beeps and reloads the timeout
         if (key >= acmc_pkg::KEY_SETUP && key <= acmc_pkg::KEY_MINUS) begin
            s.buzz_alarm   = 1'b0;
            s.buzz_left    = cfg.pip_length;
            s.buzz_cycle   = 11'd0;
            s.timeout_left = cfg.edit_timeout;
            if (key == acmc_pkg::KEY_SETUP) begin
               unique case (s.mode)
                  acmc_pkg::ST_NORMAL: begin
                     s.edit_hour   = s.hour;
                     s.edit_minute = s.minute;
                     s.mode        = acmc_pkg::ST_SET_HOUR;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  acmc_pkg::ST_SET_HOUR: begin
                     s.mode        = acmc_pkg::ST_SET_MIN;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  acmc_pkg::ST_SET_MIN: begin
                     s.hour        = s.edit_hour;
                     s.minute      = s.edit_minute;
                     s.second      = 6'd0;
                     s.mode        = acmc_pkg::ST_NORMAL;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  default: ;
               endcase
            end else if (key == acmc_pkg::KEY_ALARM) begin
               unique case (s.mode)
                  acmc_pkg::ST_NORMAL: begin
                     s.mode        = acmc_pkg::ST_ALARM_HOUR;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  acmc_pkg::ST_ALARM_HOUR: begin
                     s.mode        = acmc_pkg::ST_ALARM_MIN;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  acmc_pkg::ST_ALARM_MIN: begin
                     save          = 1'b1;
                     s.mode        = acmc_pkg::ST_NORMAL;
                     s.blink_count = 10'd0;
                     s.blink_phase = 1'b1;
                  end
                  default: ;
               endcase
            end else begin
               unique case (s.mode)
                  acmc_pkg::ST_SET_HOUR:
                     s.edit_hour = up ?
                        5'(inc_wrap({1'b0, s.edit_hour}, {1'b0, acmc_pkg::HOUR_TOP})) :
                        5'(dec_wrap({1'b0, s.edit_hour}, {1'b0, acmc_pkg::HOUR_TOP}));
                  acmc_pkg::ST_SET_MIN:
                     s.edit_minute = up ? inc_wrap(s.edit_minute, acmc_pkg::MINUTE_TOP) :
                                          dec_wrap(s.edit_minute, acmc_pkg::MINUTE_TOP);
                  acmc_pkg::ST_ALARM_HOUR:
                     s.alarm_hour = up ?
                        5'(inc_wrap({1'b0, s.alarm_hour}, {1'b0, acmc_pkg::HOUR_TOP})) :
                        5'(dec_wrap({1'b0, s.alarm_hour}, {1'b0, acmc_pkg::HOUR_TOP}));
                  acmc_pkg::ST_ALARM_MIN:
                     s.alarm_minute = up ? inc_wrap(s.alarm_minute, acmc_pkg::MINUTE_TOP) :
                                           dec_wrap(s.alarm_minute, acmc_pkg::MINUTE_TOP);
                  default: ;
               endcase
               s.blink_count = 10'd0;
               s.blink_phase = 1'b1;
            end
         end
      end else begin
         // time of day
         sec_c = {1'b0, s.second} + 7'd1;
         if (sec_c < acmc_pkg::SECONDS_MIN) begin
            s.second = sec_c[5:0];
         end else begin
            s.second = 6'd0;
            min_c = {1'b0, s.minute} + 7'd1;
            if (min_c >= acmc_pkg::MINUTES_HOUR) begin
               s.minute = 6'd0;
               hour_c = {1'b0, s.hour} + 6'd1;
               s.hour = (hour_c >= acmc_pkg::HOURS_DAY) ? 5'd0 : hour_c[4:0];
            end else begin
               s.minute = min_c[5:0];
            end
            if (s.hour == s.alarm_hour && s.minute == s.alarm_minute &&
                s.mode == acmc_pkg::ST_NORMAL) begin
               s.buzz_alarm = 1'b1;
               s.buzz_left  = cfg.alarm_length;
               s.buzz_cycle = 11'd0;
            end
         end
         // edit timeout
         if (s.mode != acmc_pkg::ST_NORMAL) begin
            if (s.timeout_left != 6'd0) begin
               s.timeout_left = s.timeout_left - 6'd1;
            end
            if (s.timeout_left == 6'd0) begin
               if (s.mode == acmc_pkg::ST_SET_HOUR || s.mode == acmc_pkg::ST_SET_MIN) begin
                  s.hour   = s.edit_hour;
                  s.minute = s.edit_minute;
                  s.second = 6'd0;
               end else begin
                  save = 1'b1;
               end
               s.mode        = acmc_pkg::ST_NORMAL;
               s.blink_count = 10'd0;
               s.blink_phase = 1'b1;
               s.buzz_alarm  = 1'b0;
               s.buzz_left   = cfg.pip_length;
               s.buzz_cycle  = 11'd0;
            end
         end
      end
      state_next = s;
   end

   // display of the state after the beat
   always_comb begin
      result              = '0;
      result.save_alarm   = save;
      result.buzzer_drive = state_next.buzz_level;
      result.hour_visible   = 1'b1;
      result.minute_visible = 1'b1;
      unique case (state_next.mode)
         acmc_pkg::ST_SET_HOUR: begin
            result.clock_mode   = acmc_pkg::MODE_CODE_SET_HOUR;
            result.shown_hour   = state_next.edit_hour;
            result.shown_minute = state_next.edit_minute;
            result.hour_visible = state_next.blink_phase;
         end
         acmc_pkg::ST_SET_MIN: begin
            result.clock_mode     = acmc_pkg::MODE_CODE_SET_MINUTE;
            result.shown_hour     = state_next.edit_hour;
            result.shown_minute   = state_next.edit_minute;
            result.minute_visible = state_next.blink_phase;
         end
         acmc_pkg::ST_ALARM_HOUR: begin
            result.clock_mode   = acmc_pkg::MODE_CODE_ALARM_HOUR;
            result.shown_hour   = state_next.alarm_hour;
            result.shown_minute = state_next.alarm_minute;
            result.hour_visible = state_next.blink_phase;
            result.alarm_led    = state_next.blink_phase;
         end
         acmc_pkg::ST_ALARM_MIN: begin
            result.clock_mode     = acmc_pkg::MODE_CODE_ALARM_MINUTE;
            result.shown_hour     = state_next.alarm_hour;
            result.shown_minute   = state_next.alarm_minute;
            result.minute_visible = state_next.blink_phase;
            result.alarm_led      = state_next.blink_phase;
         end
         default: begin
            result.clock_mode   = acmc_pkg::MODE_CODE_NORMAL;
            result.shown_hour   = state_next.hour;
            result.shown_minute = state_next.minute;
         end
      endcase
   end

endmodule

// ===== design/alarm_clock_mode_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_mode_controller: 24-hour alarm clock with set and alarm modes
// Channel  | dir | beat contents
// req      | in  | tuser: tick kind (0 ms, 1 s); tdata: key code
// rsp      | out | tdata: digits, blank flags, buzzer, LED, mode, save pulse
// csr      | in  | write enable, register index, write data
// One request beat per cycle while req_tready is high; each beat yields
// one registered response beat, held in the response register until
// taken. The state update is a single combinational pass from the state
// registers to the result register. req_tready is high when the response
// register is empty or being drained. Synchronous reset restores the time
// to 00:00, normal mode, registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module alarm_clock_mode_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [2:0] key, [7:3] zero
   input  logic                               req_tuser,  // [0] req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] shown_hour, [10:5] shown_minute, [11] hour_visible,
   // [12] minute_visible, [13] buzzer_drive, [14] alarm_led,
   // [17:15] clock_mode, [18] save_alarm, [23:19] zero
   output logic [acmc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [acmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [acmc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   acmc_pkg::state_type  state_ff;
   acmc_pkg::state_type  state_in;
   acmc_pkg::cfg_type    cfg_ff;
   acmc_pkg::result_type result_in;
   logic [acmc_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 req_take;

   acmc_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .req_type   (req_tuser),
      .key        (req_tdata[2:0]),
      .state_next (state_in),
      .result     (result_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acmc_pkg::STATE_RESET;
         cfg_ff       <= acmc_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               acmc_pkg::CSR_EDIT_TIMEOUT: cfg_ff.edit_timeout <= csr_wdata[5:0];
               acmc_pkg::CSR_BLINK_HALF:   cfg_ff.blink_half   <= csr_wdata[9:0];
               acmc_pkg::CSR_PIP_LENGTH:   cfg_ff.pip_length   <= csr_wdata;
               acmc_pkg::CSR_ALARM_LENGTH: cfg_ff.alarm_length <= csr_wdata;
               acmc_pkg::CSR_ALARM_ON:     cfg_ff.alarm_on     <= csr_wdata[9:0];
               default: ;
            endcase
         end
         // advance on an accepted beat, else hold until the response drains
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= {{(acmc_pkg::RSP_DATA_W - $bits(acmc_pkg::result_type)){1'b0}},
                         result_in};
      end
   end

endmodule

// ===== tb/alarm_clock_mode_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_mode_controller_tb: self-checking bench for the alarm clock
// Feeds millisecond and second tick beats through the request stream and
// tracks the clock, edit modes, blink and buzzer in a local model. Every
// response beat is checked field by field against that model, over several
// register settings with random bursts on the request side and random stalls
// on the response side.
// ----------------------------------------------------------------------------
module alarm_clock_mode_controller_tb;
   import acmc_pkg::*;

   localparam logic [2:0] KEY_SPARE_LO  = 3'd5;
   localparam logic [2:0] KEY_SPARE_MID = 3'd6;
   localparam logic [2:0] KEY_SPARE_HI  = 3'd7;
   localparam int         SECOND_TOP    = 59;
   localparam int         STALL_LIMIT   = 1000;

   typedef struct packed {
      logic       kind;
      logic [2:0] key;
   } tick_item;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // local copy of the registers
   logic [5:0]  cfg_edit_timeout;
   logic [9:0]  cfg_blink_half;
   logic [12:0] cfg_pip_length;
   logic [12:0] cfg_alarm_length;
   logic [9:0]  cfg_alarm_on;

   // local copy of the clock state
   logic [4:0]  time_hour, alarm_hour, edit_hour;
   logic [5:0]  time_minute, time_second, alarm_minute, edit_minute;
   logic [2:0]  mode_now;
   logic [5:0]  timeout_left;
   logic [9:0]  blink_count;
   logic        blink_phase;
   logic [12:0] buzz_left;
   logic [10:0] buzz_cycle;
   logic        buzz_is_alarm, buzz_level;

   tick_item   tick_queue[$];
   result_type expected_results[$];

   int items_queued   = 0;
   int results_seen   = 0;
   int alarms_started = 0;
   int saves_seen     = 0;
   int settings_used  = 1;
   int error_count    = 0;
   int gap_left       = 0;
   int burst_left     = 0;
   int ready_left     = 0;
   int idle_cycles    = 0;

   alarm_clock_mode_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic int wrap_step(int v, int top, logic up);
      if (up) return (v >= top) ? 0 : v + 1;
      return (v == 0 || v > top) ? top : v - 1;
   endfunction

   task automatic start_pip();
      buzz_is_alarm = 1'b0;
      buzz_left     = cfg_pip_length;
      buzz_cycle    = '0;
   endtask

   task automatic enter_mode(input logic [2:0] m);
      mode_now    = m;
      blink_count = '0;
      blink_phase = 1'b1;
      if (m != MODE_CODE_NORMAL) timeout_left = cfg_edit_timeout;
   endtask

   task automatic predict_tick(input logic kind, input logic [2:0] key,
                               output result_type res);
      logic save_now, blank_h, blank_m, up;
      int   next_blink;
      save_now = 1'b0;
      blank_h  = 1'b0;
      blank_m  = 1'b0;
      res      = '0;
      if (kind == REQ_MS_TICK) begin
         // buzzer pattern
         if (buzz_left == '0) begin
            buzz_level = 1'b0;
         end else begin
            buzz_left = buzz_left - 13'd1;
            if (!buzz_is_alarm) begin
               buzz_level = 1'b1;
            end else begin
               buzz_cycle = buzz_cycle + 11'd1;
               if (int'(buzz_cycle) < int'(cfg_alarm_on)) buzz_level = 1'b1;
               else if (int'(buzz_cycle) < 2 * int'(cfg_alarm_on)) buzz_level = 1'b0;
               else buzz_cycle = '0;
            end
            if (buzz_left == '0) begin
               buzz_level    = 1'b0;
               buzz_is_alarm = 1'b0;
               buzz_cycle    = '0;
            end
         end
         // blink phase
         next_blink = int'(blink_count) + 1;
         if (next_blink >= int'(cfg_blink_half)) begin
            blink_count = '0;
            blink_phase = ~blink_phase;
         end else begin
            blink_count = 10'(next_blink);
         end
         // key; unused codes fall through as no key
         if (key >= KEY_SETUP && key <= KEY_MINUS) begin
            start_pip();
            timeout_left = cfg_edit_timeout;
            case (key)
               KEY_SETUP: begin
                  case (mode_now)
                     MODE_CODE_NORMAL: begin
                        edit_hour   = time_hour;
                        edit_minute = time_minute;
                        enter_mode(MODE_CODE_SET_HOUR);
                     end
                     MODE_CODE_SET_HOUR: enter_mode(MODE_CODE_SET_MINUTE);
                     MODE_CODE_SET_MINUTE: begin
                        time_hour   = edit_hour;
                        time_minute = edit_minute;
                        time_second = '0;
                        enter_mode(MODE_CODE_NORMAL);
                     end
                     default: ;
                  endcase
               end
               KEY_ALARM: begin
                  case (mode_now)
                     MODE_CODE_NORMAL:     enter_mode(MODE_CODE_ALARM_HOUR);
                     MODE_CODE_ALARM_HOUR: enter_mode(MODE_CODE_ALARM_MINUTE);
                     MODE_CODE_ALARM_MINUTE: begin
                        save_now = 1'b1;
                        enter_mode(MODE_CODE_NORMAL);
                     end
                     default: ;
                  endcase
               end
               default: begin
                  up = (key == KEY_PLUS);
                  case (mode_now)
                     MODE_CODE_SET_HOUR:
                        edit_hour = 5'(wrap_step(edit_hour, HOUR_TOP, up));
                     MODE_CODE_SET_MINUTE:
                        edit_minute = 6'(wrap_step(edit_minute, MINUTE_TOP, up));
                     MODE_CODE_ALARM_HOUR:
                        alarm_hour = 5'(wrap_step(alarm_hour, HOUR_TOP, up));
                     MODE_CODE_ALARM_MINUTE:
                        alarm_minute = 6'(wrap_step(alarm_minute, MINUTE_TOP, up));
                     default: ;
                  endcase
                  blink_count = '0;
                  blink_phase = 1'b1;
               end
            endcase
         end
      end else begin
         // time runs in every mode; the alarm only arms in normal mode
         if (int'(time_second) >= SECOND_TOP) begin
            time_second = '0;
            if (time_minute >= MINUTE_TOP) begin
               time_minute = '0;
               time_hour   = (time_hour >= HOUR_TOP) ? 5'd0 : time_hour + 5'd1;
            end else begin
               time_minute = time_minute + 6'd1;
            end
            if (time_hour == alarm_hour && time_minute == alarm_minute &&
                mode_now == MODE_CODE_NORMAL) begin
               buzz_is_alarm = 1'b1;
               buzz_left     = cfg_alarm_length;
               buzz_cycle    = '0;
               alarms_started++;
            end
         end else begin
            time_second = time_second + 6'd1;
         end
         // edit timeout
         if (mode_now != MODE_CODE_NORMAL) begin
            if (timeout_left != '0) timeout_left = timeout_left - 6'd1;
            if (timeout_left == '0) begin
               if (mode_now == MODE_CODE_SET_HOUR || mode_now == MODE_CODE_SET_MINUTE) begin
                  time_hour   = edit_hour;
                  time_minute = edit_minute;
                  time_second = '0;
               end else if (mode_now == MODE_CODE_ALARM_HOUR ||
                            mode_now == MODE_CODE_ALARM_MINUTE) begin
                  save_now = 1'b1;
               end
               enter_mode(MODE_CODE_NORMAL);
               start_pip();
            end
         end
      end

      case (mode_now)
         MODE_CODE_SET_HOUR, MODE_CODE_SET_MINUTE: begin
            res.shown_hour   = edit_hour;
            res.shown_minute = edit_minute;
            blank_h          = (mode_now == MODE_CODE_SET_HOUR);
            blank_m          = (mode_now == MODE_CODE_SET_MINUTE);
         end
         MODE_CODE_ALARM_HOUR, MODE_CODE_ALARM_MINUTE: begin
            res.shown_hour   = alarm_hour;
            res.shown_minute = alarm_minute;
            blank_h          = (mode_now == MODE_CODE_ALARM_HOUR);
            blank_m          = (mode_now == MODE_CODE_ALARM_MINUTE);
            res.alarm_led    = blink_phase;
         end
         default: begin
            res.shown_hour   = time_hour;
            res.shown_minute = time_minute;
         end
      endcase
      res.hour_visible   = !(blank_h && !blink_phase);
      res.minute_visible = !(blank_m && !blink_phase);
      res.buzzer_drive   = buzz_level;
      res.clock_mode     = mode_now;
      res.save_alarm     = save_now;
   endtask

   // --------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_ticks
      tick_item   next_tick;
      result_type predicted;
      if (reset) begin
         cfg_edit_timeout = CFG_RESET.edit_timeout;
         cfg_blink_half   = CFG_RESET.blink_half;
         cfg_pip_length   = CFG_RESET.pip_length;
         cfg_alarm_length = CFG_RESET.alarm_length;
         cfg_alarm_on     = CFG_RESET.alarm_on;
         time_hour        = '0;
         time_minute      = '0;
         time_second      = '0;
         alarm_hour       = '0;
         alarm_minute     = '0;
         edit_hour        = '0;
         edit_minute      = '0;
         mode_now         = MODE_CODE_NORMAL;
         timeout_left     = '0;
         blink_count      = '0;
         blink_phase      = 1'b1;
         buzz_left        = '0;
         buzz_cycle       = '0;
         buzz_is_alarm    = 1'b0;
         buzz_level       = 1'b0;
         req_tvalid      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EDIT_TIMEOUT: cfg_edit_timeout = csr_wdata[5:0];
               CSR_BLINK_HALF:   cfg_blink_half   = csr_wdata[9:0];
               CSR_PIP_LENGTH:   cfg_pip_length   = csr_wdata[12:0];
               CSR_ALARM_LENGTH: cfg_alarm_length = csr_wdata[12:0];
               CSR_ALARM_ON:     cfg_alarm_on     = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tuser, req_tdata[2:0], predicted);
            expected_results.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || tick_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               next_tick   = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_tick.kind;
               req_tdata  <= {5'b0, next_tick.key};
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  // pick the next burst and the gap that follows it
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = $urandom_range(60, 150);
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 5);
                  end
               end
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor

   function automatic void check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : drain_results
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         results_seen++;
         if (got.save_alarm) saves_seen++;
         if (expected_results.size() == 0) begin
            $error("response beat with no tick waiting for it");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("shown_hour",     want.shown_hour,     got.shown_hour);
            check_field("shown_minute",   want.shown_minute,   got.shown_minute);
            check_field("hour_visible",   want.hour_visible,   got.hour_visible);
            check_field("minute_visible", want.minute_visible, got.minute_visible);
            check_field("buzzer_drive",   want.buzzer_drive,   got.buzzer_drive);
            check_field("alarm_led",      want.alarm_led,      got.alarm_led);
            check_field("clock_mode",     want.clock_mode,     got.clock_mode);
            check_field("save_alarm",     want.save_alarm,     got.save_alarm);
         end
      end
      // stall pattern: short stalls between ready runs, now and then a long run
      if (ready_left > 0) begin
         ready_left--;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_left  = $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
         ready_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                    : $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else if (tick_queue.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("stream stalled for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------- stimulus

   task automatic push_tick(input logic tick_kind, input logic [2:0] tick_key);
      tick_item t;
      t.kind = tick_kind;
      t.key  = tick_key;
      tick_queue.push_back(t);
      items_queued++;
   endtask

   // key beat after a few idle ticks, once in a while a second tick among them
   task automatic push_key(input logic [2:0] key);
      repeat ($urandom_range(0, 3))
         push_tick(($urandom_range(0, 7) == 0) ? REQ_SEC_TICK : REQ_MS_TICK, KEY_NONE);
      push_tick(REQ_MS_TICK, key);
   endtask

   task automatic push_presses(int from, int to, int top);
      int span;
      span = top + 1;
      if ($urandom_range(0, 1)) repeat ((to - from + span) % span)
         push_tick(REQ_MS_TICK, KEY_PLUS);
      else repeat ((from - to + span) % span)
         push_tick(REQ_MS_TICK, KEY_MINUS);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic program_registers(int timeout_s, int blink_ms, int pip_ms,
                                    int alarm_ms, int on_ms);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_EDIT_TIMEOUT;
      csr_wdata <= 13'(timeout_s);
      @(posedge clock);
      csr_index <= CSR_BLINK_HALF;
      csr_wdata <= 13'(blink_ms);
      @(posedge clock);
      csr_index <= CSR_PIP_LENGTH;
      csr_wdata <= 13'(pip_ms);
      @(posedge clock);
      csr_index <= CSR_ALARM_LENGTH;
      csr_wdata <= 13'(alarm_ms);
      @(posedge clock);
      csr_index <= CSR_ALARM_ON;
      csr_wdata <= 13'(on_ms);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // enter a set or alarm mode, step the values, leave by key or by timeout
   task automatic push_edit_session(logic alarm_side);
      logic [2:0] enter_key, k;
      int         timeout_ticks;
      enter_key     = alarm_side ? KEY_ALARM : KEY_SETUP;
      timeout_ticks = ((cfg_edit_timeout == '0) ? 1 : int'(cfg_edit_timeout)) +
                      $urandom_range(0, 2);
      push_key(enter_key);
      for (int stage = 0; stage < 2; stage++) begin
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: k = KEY_PLUS;
               4, 5, 6, 7: k = KEY_MINUS;
               8:          k = alarm_side ? KEY_SETUP : KEY_ALARM;
               default:    k = 3'($urandom_range(0, 7));
            endcase
            push_key(k);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat (timeout_ticks) push_tick(REQ_SEC_TICK, 3'($urandom_range(0, 7)));
            return;
         end
         push_key(enter_key);
      end
   endtask

   // set the time, set the alarm one minute later and let the minute roll over
   task automatic push_alarm_hit();
      int set_h, set_m, ring_h, ring_m, ring_ms;
      wait_idle();
      if (mode_now != MODE_CODE_NORMAL) begin
         repeat ((timeout_left == '0) ? 1 : int'(timeout_left))
            push_tick(REQ_SEC_TICK, KEY_NONE);
         wait_idle();
      end
      if ($urandom_range(0, 2) == 0) begin
         set_h = HOUR_TOP;
         set_m = MINUTE_TOP;
      end else begin
         set_h = $urandom_range(0, HOUR_TOP);
         set_m = $urandom_range(0, MINUTE_TOP);
      end
      ring_m = (set_m == MINUTE_TOP) ? 0 : set_m + 1;
      ring_h = (set_m != MINUTE_TOP) ? set_h : (set_h == HOUR_TOP) ? 0 : set_h + 1;
      push_tick(REQ_MS_TICK, KEY_SETUP);
      push_presses(time_hour, set_h, HOUR_TOP);
      push_tick(REQ_MS_TICK, KEY_SETUP);
      push_presses(time_minute, set_m, MINUTE_TOP);
      push_tick(REQ_MS_TICK, KEY_SETUP);
      push_tick(REQ_MS_TICK, KEY_ALARM);
      push_presses(alarm_hour, ring_h, HOUR_TOP);
      push_tick(REQ_MS_TICK, KEY_ALARM);
      push_presses(alarm_minute, ring_m, MINUTE_TOP);
      push_tick(REQ_MS_TICK, KEY_ALARM);
      repeat (SECOND_TOP + 1) begin
         if ($urandom_range(0, 3) == 0) push_tick(REQ_MS_TICK, KEY_NONE);
         push_tick(REQ_SEC_TICK, KEY_NONE);
      end
      ring_ms = (cfg_alarm_length > 13'd396) ? 400 : int'(cfg_alarm_length) + 4;
      repeat (ring_ms) push_tick(REQ_MS_TICK, KEY_NONE);
   endtask

   task automatic run_random(int count, logic with_alarm);
      int stop_at;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2: push_edit_session(1'b0);
            3, 4, 5: push_edit_session(1'b1);
            6: repeat ($urandom_range(5, 60)) push_tick(REQ_MS_TICK, KEY_NONE);
            7, 8: repeat ($urandom_range(5, 30))
               push_tick(($urandom_range(0, 3) == 0) ? REQ_SEC_TICK : REQ_MS_TICK,
                         3'($urandom_range(0, 7)));
            default: begin
               if (with_alarm) push_alarm_hit();
               else push_edit_session($urandom_range(0, 1));
            end
         endcase
      end
   endtask

   initial begin : run_stimulus
      logic [2:0] opening_keys[$];
      opening_keys = '{KEY_SPARE_LO, KEY_SPARE_MID, KEY_SPARE_HI, KEY_PLUS, KEY_MINUS,
                       KEY_SETUP, KEY_MINUS, KEY_PLUS, KEY_MINUS, KEY_ALARM,
                       KEY_SETUP, KEY_MINUS, KEY_PLUS, KEY_MINUS, KEY_SETUP,
                       KEY_ALARM, KEY_SETUP, KEY_MINUS, KEY_ALARM, KEY_MINUS, KEY_ALARM};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // opening sequence at reset values: spare codes, keys in normal mode, wrap of
      // the edit fields at both ends and of the alarm fields at the low end, cross-mode keys, alarm save
      push_tick(REQ_MS_TICK, KEY_NONE);
      push_tick(REQ_SEC_TICK, KEY_SPARE_HI);
      foreach (opening_keys[i]) push_tick(REQ_MS_TICK, opening_keys[i]);
      push_tick(REQ_SEC_TICK, KEY_NONE);
      push_tick(REQ_MS_TICK, KEY_NONE);

      program_registers(3, 4, 5, 40, 3);
      run_random(500, 1'b1);
      program_registers(63, 1023, 8191, 8191, 1023);
      run_random(250, 1'b0);
      program_registers(1, 1, 1, 1, 1);
      run_random(250, 1'b1);
      // zero registers: silent pips and alarms, blink every tick, instant timeout
      program_registers(0, 0, 0, 0, 0);
      run_random(200, 1'b1);
      // alarm on time of zero holds the buzzer level through the pattern
      program_registers(5, 7, 3, 30, 0);
      run_random(150, 1'b1);
      repeat (2) begin
         program_registers($urandom_range(1, 8), $urandom_range(1, 20),
                           $urandom_range(1, 30), $urandom_range(1, 120),
                           $urandom_range(1, 40));
         run_random(250, 1'b1);
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("checked %0d response beats over %0d register settings", results_seen,
               settings_used);
      $display("alarm starts %0d, alarm saves %0d", alarms_started, saves_seen);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== alarm_clock_mode_controller.f =====
design/acmc_pkg.sv
design/acmc_step.sv
design/alarm_clock_mode_controller.sv
tb/alarm_clock_mode_controller_tb.sv
